// ===== src/bbs_pkg.sv =====
`default_nettype none

package bbs_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MAX_HALF_DEF   = 2;

    localparam int PIX_W    = 8;
    localparam int COORD_W  = 10;
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 13;
    localparam int SIZE_W   = 11;
    localparam int HALF_W   = 2;
    localparam int THR_W    = 13;
    localparam int WGT_W    = 9;
    localparam int LOCK_W   = 8;

    localparam logic [SIZE_W-1:0] RST_WIDTH  = 11'd640;
    localparam logic [SIZE_W-1:0] RST_HEIGHT = 11'd480;
    localparam logic [HALF_W-1:0] RST_HALF   = 2'd1;
    localparam logic [THR_W-1:0]  RST_THRESH = 13'd30;
    localparam logic [WGT_W-1:0]  RST_WEIGHT = 9'd13;
    localparam logic [LOCK_W-1:0] RST_LOCK   = 8'd50;

    localparam logic [WGT_W-1:0]  WEIGHT_ONE = 9'd256;
    localparam logic [LOCK_W-1:0] COUNT_MAX  = 8'd255;

    typedef enum logic [CFG_IW-1:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_HALF   = 3'd2,
        REG_THRESH = 3'd3,
        REG_WEIGHT = 3'd4,
        REG_LOCK   = 3'd5
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_OLD_WR,
        S_WIN,
        S_DRAIN,
        S_LOAD,
        S_BLEND,
        S_WB
    } t_state;

endpackage

`default_nettype wire

// ===== src/block_background_subtractor.sv =====
// Background subtractor for a BGR pixel stream in raster order.
// Pixels enter on the input channel (i_in_valid / o_in_ready) with
// i_frame_start high on the first pixel of each frame. The first full
// frame after reset is only stored as background. For every later frame
// each interior pixel gives one result on the output channel
// (o_out_valid / i_out_ready): its row, column, foreground flag and a
// frame_done flag on the last interior result of the frame.
// Configuration writes use i_cfg_valid / o_cfg_ready with a register
// index and data; write them only while the block is idle.
// A pixel is accepted only in the idle state. A loading-frame or ignored
// pixel needs nothing more; a border pixel then passes through the old-write
// state and an interior pixel through the old-write, window, drain, load,
// blend and write-back states, reading the window one line buffer entry per
// cycle. After reset a clearing pass zeroes the state memory, all
// 2^(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) entries (1048576 by default), one
// entry per cycle; no pixel is taken meanwhile. A result waits in an output
// register while the receiver stalls; the next pixel is still accepted.
`default_nettype none

module block_background_subtractor #(
    parameter int MAX_WIDTH  = bbs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbs_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_HALF   = bbs_pkg::MAX_HALF_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  [bbs_pkg::PIX_W-1:0]    i_blue,
    input  wire  [bbs_pkg::PIX_W-1:0]    i_green,
    input  wire  [bbs_pkg::PIX_W-1:0]    i_red,
    input  wire                          i_frame_start,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [bbs_pkg::COORD_W-1:0]  o_pixel_row,
    output logic [bbs_pkg::COORD_W-1:0]  o_pixel_col,
    output logic                         o_foreground,
    output logic                         o_frame_done,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [bbs_pkg::CFG_IW-1:0]   i_cfg_index,
    input  wire  [bbs_pkg::CFG_DW-1:0]   i_cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WIN  = 2 * MAX_HALF + 1;
    localparam int LW   = (WIN > 1) ? $clog2(WIN) : 1;
    localparam int KW   = $clog2(WIN + 1);
    localparam int SUMW = $clog2(WIN * WIN * 255 + 1);
    localparam int CMPW = (SUMW > bbs_pkg::THR_W) ? SUMW : bbs_pkg::THR_W;
    localparam int SAW  = RW + CW;
    localparam int LAW  = LW + CW;
    localparam int PW   = bbs_pkg::PIX_W;
    localparam int OW   = bbs_pkg::COORD_W;

    // configuration
    logic [bbs_pkg::SIZE_W-1:0] r_cfg_width, r_cfg_height;
    logic [bbs_pkg::HALF_W-1:0] r_cfg_half;
    logic [bbs_pkg::THR_W-1:0]  r_cfg_thresh;
    logic [bbs_pkg::WGT_W-1:0]  r_cfg_weight;
    logic [bbs_pkg::LOCK_W-1:0] r_cfg_lock;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= bbs_pkg::RST_WIDTH;
            r_cfg_height <= bbs_pkg::RST_HEIGHT;
            r_cfg_half   <= bbs_pkg::RST_HALF;
            r_cfg_thresh <= bbs_pkg::RST_THRESH;
            r_cfg_weight <= bbs_pkg::RST_WEIGHT;
            r_cfg_lock   <= bbs_pkg::RST_LOCK;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bbs_pkg::REG_WIDTH:  r_cfg_width  <= i_cfg_data[bbs_pkg::SIZE_W-1:0];
                bbs_pkg::REG_HEIGHT: r_cfg_height <= i_cfg_data[bbs_pkg::SIZE_W-1:0];
                bbs_pkg::REG_HALF:   r_cfg_half   <= i_cfg_data[bbs_pkg::HALF_W-1:0];
                bbs_pkg::REG_THRESH: r_cfg_thresh <= i_cfg_data[bbs_pkg::THR_W-1:0];
                bbs_pkg::REG_WEIGHT: r_cfg_weight <= i_cfg_data[bbs_pkg::WGT_W-1:0];
                bbs_pkg::REG_LOCK:   r_cfg_lock   <= i_cfg_data[bbs_pkg::LOCK_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped settings
    logic [CW:0]                c_w;
    logic [RW:0]                c_h;
    logic [KW-1:0]              c_half, c_half2;
    logic [bbs_pkg::WGT_W-1:0]  c_wgt;

    always_comb begin
        if (r_cfg_width == '0) c_w = (CW+1)'(1);
        else if (32'(r_cfg_width) > MAX_WIDTH) c_w = (CW+1)'(MAX_WIDTH);
        else c_w = (CW+1)'(r_cfg_width);
        if (r_cfg_height == '0) c_h = (RW+1)'(1);
        else if (32'(r_cfg_height) > MAX_HEIGHT) c_h = (RW+1)'(MAX_HEIGHT);
        else c_h = (RW+1)'(r_cfg_height);
        if (32'(r_cfg_half) > MAX_HALF) c_half = KW'(MAX_HALF);
        else c_half = KW'(r_cfg_half);
        c_half2 = KW'(32'(c_half) * 2);
        if (r_cfg_weight > bbs_pkg::WEIGHT_ONE) c_wgt = bbs_pkg::WEIGHT_ONE;
        else c_wgt = r_cfg_weight;
    end

    // memories
    logic [31:0]     r_st_mem [2**SAW];
    logic [2*24-1:0] r_ln_mem [2**LAW];
    logic [31:0]     r_st_q;
    logic [2*24-1:0] r_ln_q;

    logic            st_we, ln_we;
    logic [SAW-1:0]  st_wa, st_ra;
    logic [31:0]     st_wd;
    logic [LAW-1:0]  ln_wa, ln_ra;
    logic [2*24-1:0] ln_wd;

    always_ff @(posedge i_clk) begin
        if (st_we) r_st_mem[st_wa] <= st_wd;
        r_st_q <= r_st_mem[st_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ln_we) r_ln_mem[ln_wa] <= ln_wd;
        r_ln_q <= r_ln_mem[ln_ra];
    end

    // state and raster
    bbs_pkg::t_state r_state, n_state;
    logic [SAW-1:0]  r_clr;
    logic [RW-1:0]   r_rrow, r_row;
    logic [CW-1:0]   r_rcol, r_col;
    logic [LW-1:0]   r_rline, r_line, r_wl;
    logic            r_fover, r_loaded;
    logic [23:0]     r_pix, r_inp, r_cur, r_blend;
    logic [KW-1:0]   r_dr, r_dc;
    logic            r_rd_v, r_ctr_v;
    logic [SUMW-1:0] r_si [3];
    logic [SUMW-1:0] r_sb [3];
    logic [bbs_pkg::LOCK_W-1:0] r_cnt;
    logic            r_fg;
    logic [1:0]      r_ch;

    logic            r_out_v;
    logic [OW-1:0]   r_o_row, r_o_col;
    logic            r_o_fg, r_o_done;

    logic            in_acc, a_fover, a_ign, a_col_last, a_row_last;
    logic [RW-1:0]   a_row;
    logic [CW-1:0]   a_col;
    logic [LW-1:0]   a_line;
    logic            interior, win_last, wb_go;
    logic [RW-1:0]   cr;
    logic [CW-1:0]   cc;
    logic [LW-1:0]   wl0;

    assign o_in_ready = (r_state == bbs_pkg::S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        a_row   = i_frame_start ? '0 : r_rrow;
        a_col   = i_frame_start ? '0 : r_rcol;
        a_line  = i_frame_start ? '0 : r_rline;
        a_fover = i_frame_start ? 1'b0 : r_fover;
        a_ign   = a_fover || ({1'b0, a_row} >= c_h) || ({1'b0, a_col} >= c_w);
        a_col_last = (({1'b0, a_col} + (CW+1)'(1)) >= c_w);
        a_row_last = (({1'b0, a_row} + (RW+1)'(1)) >= c_h);
    end

    always_comb begin
        interior = (32'(r_row) >= 32'(c_half2)) && (32'(r_col) >= 32'(c_half2));
        cr       = r_row - RW'(c_half);
        cc       = r_col - CW'(c_half);
        win_last = (r_dr == c_half2) && (r_dc == c_half2);
        wb_go    = !r_out_v || i_out_ready;
        if (32'(r_line) >= 32'(c_half2)) wl0 = LW'(32'(r_line) - 32'(c_half2));
        else wl0 = LW'(32'(r_line) + WIN - 32'(c_half2));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bbs_pkg::S_CLEAR:  if (&r_clr) n_state = bbs_pkg::S_IDLE;
            bbs_pkg::S_IDLE:   if (in_acc && !a_ign && r_loaded) n_state = bbs_pkg::S_OLD_WR;
            bbs_pkg::S_OLD_WR: n_state = interior ? bbs_pkg::S_WIN : bbs_pkg::S_IDLE;
            bbs_pkg::S_WIN:    if (win_last) n_state = bbs_pkg::S_DRAIN;
            bbs_pkg::S_DRAIN:  n_state = bbs_pkg::S_LOAD;
            bbs_pkg::S_LOAD:   n_state = bbs_pkg::S_BLEND;
            bbs_pkg::S_BLEND:  if (r_ch == 2'd2) n_state = bbs_pkg::S_WB;
            bbs_pkg::S_WB:     if (wb_go) n_state = bbs_pkg::S_IDLE;
            default:           n_state = bbs_pkg::S_IDLE;
        endcase
    end

    // final counter and background for write-back
    logic [bbs_pkg::LOCK_W-1:0] f_cnt;
    logic [23:0]                f_cur;

    always_comb begin
        if (r_fg) begin
            f_cnt = '0;
            f_cur = r_cur;
        end else if (r_cnt != bbs_pkg::COUNT_MAX) begin
            f_cnt = r_cnt + 1'b1;
            f_cur = r_blend;
        end else begin
            f_cnt = r_cnt;
            f_cur = r_cur;
        end
        if (f_cnt < r_cfg_lock) f_cur = r_inp;
    end

    // memory controls
    always_comb begin
        st_we = 1'b0;
        st_wa = {r_row, r_col};
        st_wd = '0;
        st_ra = {a_row, a_col};
        ln_we = 1'b0;
        ln_wa = {r_line, r_col};
        ln_wd = {r_st_q[23:0], r_pix};
        ln_ra = {r_wl, CW'(32'(r_col) - 32'(c_half2) + 32'(r_dc))};
        case (r_state)
            bbs_pkg::S_CLEAR: begin
                st_we = 1'b1;
                st_wa = r_clr;
            end
            bbs_pkg::S_IDLE: begin
                st_we = in_acc && !a_ign && !r_loaded;
                st_wa = {a_row, a_col};
                st_wd = {8'd0, i_red, i_green, i_blue};
            end
            bbs_pkg::S_OLD_WR: ln_we = 1'b1;
            bbs_pkg::S_DRAIN:  st_ra = {cr, cc};
            bbs_pkg::S_WB: begin
                st_we = wb_go;
                st_wa = {cr, cc};
                st_wd = {f_cnt, f_cur};
            end
            default: ;
        endcase
    end

    // blend of one channel: old + ((w*(in-old) + 128) >>> 8)
    logic [PW-1:0]        b_in, b_old;
    logic signed [9:0]    b_d;
    logic signed [19:0]   b_p, b_t;
    logic [9:0]           b_v;

    always_comb begin
        b_in  = r_inp[PW*r_ch +: PW];
        b_old = r_cur[PW*r_ch +: PW];
        b_d   = $signed({2'b00, b_in}) - $signed({2'b00, b_old});
        b_p   = $signed({1'b0, c_wgt}) * b_d;
        b_t   = (b_p + 20'sd128) >>> 8;
        b_v   = {2'b00, b_old} + b_t[9:0];
    end

    // closeness test on finished sums
    logic            l_fg;
    logic [SUMW-1:0] l_diff [3];

    always_comb begin
        l_fg = 1'b0;
        for (int c = 0; c < 3; c++) begin
            l_diff[c] = (r_si[c] > r_sb[c]) ? r_si[c] - r_sb[c] : r_sb[c] - r_si[c];
            if (!(CMPW'(l_diff[c]) < CMPW'(r_cfg_thresh))) l_fg = 1'b1;
        end
    end

    logic [RW+OW-1:0] o_row_ext;
    logic [CW+OW-1:0] o_col_ext;
    assign o_row_ext = {{OW{1'b0}}, cr};
    assign o_col_ext = {{OW{1'b0}}, cc};

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bbs_pkg::S_CLEAR;
            r_clr    <= '0;
            r_rrow   <= '0;
            r_rcol   <= '0;
            r_rline  <= '0;
            r_fover  <= 1'b0;
            r_loaded <= 1'b0;
            r_rd_v   <= 1'b0;
            r_ctr_v  <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == bbs_pkg::S_CLEAR) r_clr <= r_clr + 1'b1;
            if (in_acc) begin
                if (a_ign) begin
                    r_fover <= 1'b1;
                    r_rrow  <= a_row;
                    r_rcol  <= a_col;
                    r_rline <= a_line;
                end else if (a_col_last) begin
                    r_rcol <= '0;
                    if (a_row_last) begin
                        r_fover  <= 1'b1;
                        r_loaded <= 1'b1;
                        r_rrow   <= a_row;
                        r_rline  <= a_line;
                    end else begin
                        r_fover <= 1'b0;
                        r_rrow  <= a_row + 1'b1;
                        r_rline <= (32'(a_line) == WIN - 1) ? '0 : a_line + 1'b1;
                    end
                end else begin
                    r_fover <= 1'b0;
                    r_rrow  <= a_row;
                    r_rcol  <= a_col + 1'b1;
                    r_rline <= a_line;
                end
            end
            r_rd_v  <= (r_state == bbs_pkg::S_WIN);
            r_ctr_v <= (r_state == bbs_pkg::S_WIN) && (r_dr == c_half) && (r_dc == c_half);
            if (r_state == bbs_pkg::S_WB && wb_go) r_out_v <= 1'b1;
            else if (i_out_ready) r_out_v <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_row  <= a_row;
            r_col  <= a_col;
            r_line <= a_line;
            r_pix  <= {i_red, i_green, i_blue};
        end
        case (r_state)
            bbs_pkg::S_OLD_WR: begin
                r_dr <= '0;
                r_dc <= '0;
                r_wl <= wl0;
                for (int c = 0; c < 3; c++) begin
                    r_si[c] <= '0;
                    r_sb[c] <= '0;
                end
            end
            bbs_pkg::S_WIN: begin
                if (r_dc == c_half2) begin
                    r_dc <= '0;
                    r_dr <= r_dr + 1'b1;
                    r_wl <= (32'(r_wl) == WIN - 1) ? '0 : r_wl + 1'b1;
                end else begin
                    r_dc <= r_dc + 1'b1;
                end
            end
            bbs_pkg::S_LOAD: begin
                r_cnt <= r_st_q[31:24];
                r_cur <= r_st_q[23:0];
                r_fg  <= l_fg;
                r_ch  <= '0;
            end
            bbs_pkg::S_BLEND: begin
                r_blend[PW*r_ch +: PW] <= b_v[PW-1:0];
                r_ch <= r_ch + 1'b1;
            end
            bbs_pkg::S_WB: begin
                if (wb_go) begin
                    r_o_row  <= o_row_ext[OW-1:0];
                    r_o_col  <= o_col_ext[OW-1:0];
                    r_o_fg   <= r_fg;
                    r_o_done <= ({1'b0, r_row} == c_h - 1'b1) && ({1'b0, r_col} == c_w - 1'b1);
                end
            end
            default: ;
        endcase
        if (r_rd_v) begin
            for (int c = 0; c < 3; c++) begin
                r_si[c] <= r_si[c] + SUMW'(r_ln_q[PW*c +: PW]);
                r_sb[c] <= r_sb[c] + SUMW'(r_ln_q[24 + PW*c +: PW]);
            end
        end
        if (r_ctr_v) r_inp <= r_ln_q[23:0];
    end

    assign o_out_valid  = r_out_v;
    assign o_pixel_row  = r_o_row;
    assign o_pixel_col  = r_o_col;
    assign o_foreground = r_o_fg;
    assign o_frame_done = r_o_done;

    a_acc_to_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == bbs_pkg::S_IDLE || r_state == bbs_pkg::S_OLD_WR))
        else $error("accepted pixel led to an unexpected state");

    a_wb_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bbs_pkg::S_WB && wb_go) |=> r_out_v)
        else $error("write-back finished without a result");

    a_read_follows_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_v |-> $past(r_state == bbs_pkg::S_WIN))
        else $error("window read data without a read");

    a_sums_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bbs_pkg::S_LOAD) |-> !r_rd_v)
        else $error("window sums still open at load");

    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_rline) < WIN)
        else $error("line index out of range");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int LOAD_W = 40;
    localparam int LOAD_H = 12;
    localparam int LINES  = 2 * bbs_pkg::MAX_HALF_DEF + 1;

    typedef struct packed {
        bit [bbs_pkg::COORD_W-1:0] row;
        bit [bbs_pkg::COORD_W-1:0] col;
        bit                        fg;
        bit                        done;
    } t_pixel_class;

    // Running-average background model with the queue of classifications it predicts.
    class t_bg_scoreboard;
        int unsigned width_r = 640, height_r = 480, half_r = 1;
        int unsigned thresh_r = 30, weight_r = 13, lock_r = 50;
        bit [23:0] bg_mem [int];
        bit [7:0]  lock_mem [int];
        bit [23:0] cur_line [LINES][bbs_pkg::MAX_WIDTH_DEF];
        bit [23:0] old_line [LINES][bbs_pkg::MAX_WIDTH_DEF];
        int unsigned r_row, r_col;
        bit loaded, over;
        t_pixel_class pending [$];

        function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void write_reg(bbs_pkg::t_reg_idx idx, int unsigned val);
            case (idx)
                bbs_pkg::REG_WIDTH:  width_r  = val & 'h7FF;
                bbs_pkg::REG_HEIGHT: height_r = val & 'h7FF;
                bbs_pkg::REG_HALF:   half_r   = val & 'h3;
                bbs_pkg::REG_THRESH: thresh_r = val & 'h1FFF;
                bbs_pkg::REG_WEIGHT: weight_r = val & 'h1FF;
                bbs_pkg::REG_LOCK:   lock_r   = val & 'hFF;
                default: ;
            endcase
        endfunction

        function void note_pixel(bit [7:0] b, bit [7:0] g, bit [7:0] r, bit fs);
            bit [23:0] px, cur, inp;
            int unsigned wd, ht, hh, wt, rw, cl, cr, cc, ci, close, si, sbk, d, cnt, v, ln;
            bit fg;
            t_pixel_class res;
            px = {r, g, b};
            wd = clamp(width_r, 1, bbs_pkg::MAX_WIDTH_DEF);
            ht = clamp(height_r, 1, bbs_pkg::MAX_HEIGHT_DEF);
            hh = clamp(half_r, 0, bbs_pkg::MAX_HALF_DEF);
            wt = clamp(weight_r, 0, 256);
            if (fs) begin
                r_row = 0;
                r_col = 0;
                over = 0;
            end
            if (over || r_row >= ht || r_col >= wd) begin
                over = 1;
                return;
            end
            rw = r_row;
            cl = r_col;
            if (!loaded) begin
                bg_mem[rw * bbs_pkg::MAX_WIDTH_DEF + cl] = px;
            end else begin
                cur_line[rw % LINES][cl] = px;
                old_line[rw % LINES][cl] = bg_mem.exists(rw * bbs_pkg::MAX_WIDTH_DEF + cl) ?
                                           bg_mem[rw * bbs_pkg::MAX_WIDTH_DEF + cl] : '0;
                if (rw >= 2 * hh && cl >= 2 * hh) begin
                    cr = rw - hh;
                    cc = cl - hh;
                    ci = cr * bbs_pkg::MAX_WIDTH_DEF + cc;
                    cnt = lock_mem.exists(ci) ? lock_mem[ci] : 0;
                    cur = bg_mem.exists(ci) ? bg_mem[ci] : '0;
                    inp = cur_line[cr % LINES][cc];
                    close = 0;
                    for (int c = 0; c < 3; c++) begin
                        si = 0;
                        sbk = 0;
                        for (int dr = 0; dr <= 2 * hh; dr++) begin
                            ln = (rw - 2 * hh + dr) % LINES;
                            for (int dc = 0; dc <= 2 * hh; dc++) begin
                                si  += cur_line[ln][cl - 2 * hh + dc][8*c +: 8];
                                sbk += old_line[ln][cl - 2 * hh + dc][8*c +: 8];
                            end
                        end
                        d = si > sbk ? si - sbk : sbk - si;
                        if (d < thresh_r) close++;
                    end
                    fg = close < 3;
                    if (!fg) begin
                        if (cnt != 255) begin
                            cnt++;
                            for (int c = 0; c < 3; c++) begin
                                v = (wt * inp[8*c +: 8] + (256 - wt) * cur[8*c +: 8] + 128) >> 8;
                                cur[8*c +: 8] = v[7:0];
                            end
                        end
                    end else begin
                        cnt = 0;
                    end
                    if (cnt < lock_r) cur = inp;
                    lock_mem[ci] = cnt[7:0];
                    bg_mem[ci] = cur;
                    res.row  = cr[bbs_pkg::COORD_W-1:0];
                    res.col  = cc[bbs_pkg::COORD_W-1:0];
                    res.fg   = fg;
                    res.done = (rw == ht - 1 && cl == wd - 1);
                    pending.push_back(res);
                end
            end
            if (cl + 1 >= wd) begin
                r_col = 0;
                if (rw + 1 >= ht) begin
                    over = 1;
                    loaded = 1;
                end else begin
                    r_row = rw + 1;
                end
            end else begin
                r_col = cl + 1;
            end
        endfunction

        // Return an empty string when the result matches the oldest classification.
        function string check_result(t_pixel_class got);
            t_pixel_class want;
            if (pending.size() == 0)
                return $sformatf("unexpected result row %0d col %0d", got.row, got.col);
            want = pending.pop_front();
            if (got != want)
                return $sformatf("row %0d/%0d col %0d/%0d fg %0b/%0b done %0b/%0b (got/exp)",
                                 got.row, want.row, got.col, want.col,
                                 got.fg, want.fg, got.done, want.done);
            return "";
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic in_valid, frame_start, out_ready, cfg_valid;
    logic [bbs_pkg::PIX_W-1:0] blue, green, red;
    logic [bbs_pkg::CFG_IW-1:0] cfg_index;
    logic [bbs_pkg::CFG_DW-1:0] cfg_data;
    logic in_ready, out_valid, cfg_ready, foreground, frame_done;
    logic [bbs_pkg::COORD_W-1:0] pixel_row, pixel_col;

    t_bg_scoreboard model;
    int mismatches;
    int results_seen;
    int pixels_sent;
    bit calm;
    bit [23:0] scene [LOAD_H][LOAD_W];

    block_background_subtractor i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_blue(blue), .i_green(green), .i_red(red), .i_frame_start(frame_start),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_pixel_row(pixel_row), .o_pixel_col(pixel_col),
        .o_foreground(foreground), .o_frame_done(frame_done),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #6 i_clk = ~i_clk;

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    function automatic int gap_len();
        int p;
        if (calm) return 0;
        p = $urandom_range(99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 6);
    endfunction

    // Sample at the falling edge; inputs only change at the rising edge.
    always @(negedge i_clk) begin
        t_pixel_class got;
        string msg;
        if (i_rst_n && out_valid && out_ready) begin
            got = '{row: pixel_row, col: pixel_col, fg: foreground, done: frame_done};
            msg = model.check_result(got);
            if (msg != "") report(msg);
            results_seen++;
        end
    end

    // Receiver: random stalls, one long hold-off to back the block up.
    int stall_left;
    bit held;
    always @(posedge i_clk) begin
        if (!held && results_seen >= 150) begin
            held <= 1;
            stall_left <= 500;
            out_ready <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 0;
        end else if (calm || $urandom_range(99) < 70) begin
            out_ready <= 1;
        end else begin
            out_ready <= 0;
            stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(2);
        end
    end

    task automatic write_reg(bbs_pkg::t_reg_idx idx, int unsigned val);
        bit ok;
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val[bbs_pkg::CFG_DW-1:0];
        do begin
            @(negedge i_clk);
            ok = cfg_ready;
            @(posedge i_clk);
        end while (!ok);
        model.write_reg(idx, val);
        cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic send_pixel(bit [23:0] px, bit fs);
        int gap;
        bit ok;
        gap = gap_len();
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid    <= 1;
        blue        <= px[7:0];
        green       <= px[15:8];
        red         <= px[23:16];
        frame_start <= fs;
        do begin
            @(negedge i_clk);
            ok = in_ready;
            @(posedge i_clk);
        end while (!ok);
        model.note_pixel(px[7:0], px[15:8], px[23:16], fs);
        pixels_sent++;
    endtask

    // Drain: hold input, wait for every classification, then cover the longest latency.
    task automatic wait_idle();
        in_valid <= 0;
        while (model.pending.size() != 0) @(posedge i_clk);
        repeat (48) @(posedge i_clk);
    endtask

    task automatic set_config(int unsigned wd, int unsigned ht, int unsigned hh,
                              int unsigned thr, int unsigned wt, int unsigned lk);
        write_reg(bbs_pkg::REG_WIDTH, wd);
        write_reg(bbs_pkg::REG_HEIGHT, ht);
        write_reg(bbs_pkg::REG_HALF, hh);
        write_reg(bbs_pkg::REG_THRESH, thr);
        write_reg(bbs_pkg::REG_WEIGHT, wt);
        write_reg(bbs_pkg::REG_LOCK, lk);
    endtask

    function automatic bit [23:0] scene_pixel(int rw, int cl, bit blob);
        bit [23:0] px;
        int v;
        if (blob) return 24'($urandom());
        for (int c = 0; c < 3; c++) begin
            v = int'(scene[rw][cl][8*c +: 8]) + $urandom_range(6) - 3;
            px[8*c +: 8] = v < 0 ? 8'd0 : (v > 255 ? 8'd255 : v[7:0]);
        end
        return px;
    endfunction

    task automatic send_frame(int wd, int ht, bit noisy);
        int br, bc, bw, bh;
        bit blob;
        br = $urandom_range(ht - 1);
        bc = $urandom_range(wd - 1);
        bh = $urandom_range(4);
        bw = $urandom_range(6);
        for (int rw = 0; rw < ht; rw++) begin
            for (int cl = 0; cl < wd; cl++) begin
                blob = rw >= br && rw < br + bh && cl >= bc && cl < bc + bw;
                // restart the frame now and then
                if (noisy && (rw | cl) != 0 && $urandom_range(199) == 0) begin
                    send_pixel(scene_pixel(0, 0, 0), 1);
                    return;
                end
                send_pixel(scene_pixel(rw, cl, blob), rw == 0 && cl == 0);
            end
        end
        if (noisy && $urandom_range(3) == 0)
            repeat ($urandom_range(3, 1)) send_pixel(24'($urandom()), 0);
    endtask

    initial begin
        int wd, ht, hh, thr, wt, lk, p;
        i_rst_n = 0;
        in_valid = 0;
        frame_start = 0;
        blue = 0;
        green = 0;
        red = 0;
        cfg_valid = 0;
        cfg_index = bbs_pkg::REG_WIDTH;
        cfg_data = 0;
        model = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        foreach (scene[r, c]) scene[r][c] = 24'($urandom());

        // load the background with the largest frame used later
        set_config(LOAD_W, LOAD_H, 1, 30, 13, 50);
        calm = 1;
        for (int rw = 0; rw < LOAD_H; rw++)
            for (int cl = 0; cl < LOAD_W; cl++)
                send_pixel(scene[rw][cl], rw == 0 && cl == 0);
        wait_idle();
        calm = 0;

        // register extremes, then a single-pixel window on extreme pixels
        write_reg(bbs_pkg::REG_WIDTH, 2047);
        write_reg(bbs_pkg::REG_HEIGHT, 1024);
        set_config(4, 3, 0, 8191, 256, 255);
        send_pixel(24'h000000, 1);
        send_pixel(24'hFFFFFF, 0);
        send_pixel(24'hFF00FF, 0);
        send_pixel(24'h00FF00, 0);
        for (int i = 0; i < 8; i++) send_pixel(24'($urandom()), 0);
        // excess pixels after the frame ends
        send_pixel(24'h123456, 0);
        send_pixel(24'hABCDEF, 0);
        wait_idle();
        // window larger than the frame
        set_config(3, 3, 3, 0, 0, 0);
        for (int i = 0; i < 9; i++) send_pixel(24'($urandom()), i == 0);
        wait_idle();

        // size shrunk mid-frame: the rest of the frame is dropped
        set_config(10, 6, 1, 200, 128, 10);
        for (int i = 0; i < 25; i++) send_pixel(scene_pixel(i / 10, i % 10, 0), i == 0);
        wait_idle();
        write_reg(bbs_pkg::REG_HEIGHT, 2);
        for (int i = 0; i < 6; i++) send_pixel(24'($urandom()), 0);
        wait_idle();

        while (pixels_sent < 1800) begin
            p = $urandom_range(9);
            wd = p == 0 ? $urandom_range(3, 1) : $urandom_range(LOAD_W, 6);
            ht = p == 1 ? $urandom_range(2, 1) : $urandom_range(LOAD_H, 4);
            hh = $urandom_range(3);
            p = $urandom_range(9);
            thr = p == 0 ? 0 : (p == 1 ? 8191 : $urandom_range(40 * (2 * hh + 1) ** 2, 1));
            p = $urandom_range(9);
            wt = p == 0 ? 0 : (p == 1 ? 256 : (p == 2 ? 511 : $urandom_range(255)));
            p = $urandom_range(9);
            lk = p == 0 ? 0 : (p == 1 ? 255 : $urandom_range(8));
            calm = $urandom_range(3) == 0;
            set_config(wd, ht, hh, thr, wt, lk);
            repeat ($urandom_range(3, 1)) send_frame(wd, ht, 1);
            wait_idle();
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #72_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
